>>> hw/rtl/assert_macros.svh
// Assertion macros, included by pagerank_push_update_unit.sv.
// Uses clk_i and rst_ni of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define PPU_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define PPU_ASSERT(lbl, prop)
`define PPU_NEVER(lbl, expr)
`endif
`endif

>>> hw/rtl/ppu_pkg.sv
// Package of the push PageRank update unit: widths, constants, word types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;
  localparam int NUM_VERTICES = 4096;
  localparam int VTX_W        = $clog2(NUM_VERTICES);
  localparam int RANK_W       = 48;
  localparam int DEG_W        = 16;
  // the serial divider only handles rank / degree
  localparam int DIV_W        = RANK_W;
  localparam int CNT_W        = $clog2(DIV_W);

  // divide by 6: 16-bit digits, MSB first, reciprocal multiply per digit
  localparam int DIG_W        = 16;
  localparam int NUM_DIG      = RANK_W / DIG_W;
  localparam int DCNT_W       = $clog2(NUM_DIG);
  localparam int RECIP_W      = 20;
  localparam int RECIP_SH     = 22;
  // ceil(2^22 / 6), exact for digit values below 2^21
  localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(699051);

  localparam logic [RANK_W-1:0] RANK_INIT = RANK_W'(100000);
  localparam logic [RANK_W-1:0] RANK_BASE = RANK_W'(15000);
  localparam logic [RANK_W-1:0] RANK_MAX  = '1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_APPLY = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [VTX_W-1:0] src_vertex;
    logic [VTX_W-1:0] dst_vertex;
    logic [DEG_W-1:0] src_degree;
  } in_word_t;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [RANK_W-1:0] rank_value;
    logic              saturated;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEG_W-1:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

>>> hw/rtl/pagerank_push_update_unit.sv
// Sequence per item: a push with nonzero degree passes S_RD, S_DIV (the
// one-bit-per-cycle divider), S_CALC and S_FIN; an apply passes S_RD, S_APL
// (three 16-bit digit steps of the divide by 6), S_CALC and S_FIN; read,
// zero-degree push and other items pass S_RD and S_FIN. One item is in
// flight. A new word is taken while the previous result waits.
// Reset: a clearing pass writes rank 100000 and accumulator 0 into every
// vertex; no word is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pagerank_push_update_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ppu_pkg::in_word_t  in_word_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output ppu_pkg::out_word_t      out_word_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i
);
  import ppu_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_APL   = 7'b0010000,
    S_CALC  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [VTX_W-1:0]  clr_cnt_q;
  in_word_t          item_q;
  logic [RANK_W-1:0] acc_q, res_q, res_d;
  logic              sat_q, sat_d;
  out_word_t         out_q;
  logic              out_valid_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [RANK_W-1:0] dq_q;
  logic [2:0]        drem_q;

  logic              accept, clearing, out_free, need_div;
  logic [RANK_W-1:0] rank_rd, acc_rd, rank_wd, acc_wd;
  logic              rank_we, acc_we;
  logic [VTX_W-1:0]  rank_ra;
  logic [RANK_W:0]   sum;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  quot;
  logic [DIG_W+2:0]  dig_val, dig_rem;
  logic [DIG_W+RECIP_W+2:0] dig_prod;
  logic [DIG_W-1:0]  dig_quo;
  logic [RANK_W-1:0] scaled;

  assign clearing   = state_q == S_CLEAR;
  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign need_div   = (item_q.op == OP_PUSH) && (item_q.src_degree != '0);

  // rank and accumulator memories
  assign rank_ra = (in_word_i.op == OP_PUSH) ? in_word_i.src_vertex : in_word_i.dst_vertex;

  ppu_ram #(.DEPTH(NUM_VERTICES), .WIDTH(RANK_W)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (clearing ? clr_cnt_q : item_q.dst_vertex),
    .wdata_i (rank_wd),
    .re_i    (accept),
    .raddr_i (rank_ra),
    .rdata_o (rank_rd)
  );

  ppu_ram #(.DEPTH(NUM_VERTICES), .WIDTH(RANK_W)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (clearing ? clr_cnt_q : item_q.dst_vertex),
    .wdata_i (acc_wd),
    .re_i    (accept),
    .raddr_i (in_word_i.dst_vertex),
    .rdata_o (acc_rd)
  );

  // divider for push: rank / degree
  always_comb begin
    div_req.start    = (state_q == S_RD) && need_div;
    div_req.dividend = rank_rd;
    div_req.divisor  = item_q.src_degree;
  end

  ppu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // apply: one digit of acc / 6 per cycle, then 5*q + floor(5*r/6)
  always_comb begin
    dig_val  = {drem_q, acc_q[RANK_W-1 -: DIG_W]};
    dig_prod = {{RECIP_W{1'b0}}, dig_val} * {{(DIG_W+3){1'b0}}, RECIP6};
    dig_quo  = dig_prod[RECIP_SH +: DIG_W];
    dig_rem  = dig_val - ((DIG_W+3)'({dig_quo, 2'b00}) + (DIG_W+3)'({dig_quo, 1'b0}));
    // floor(5*r/6) is r - 1 for r in 1..5
    scaled   = {dq_q[RANK_W-3:0], 2'b00} + dq_q +
               ((drem_q == 3'd0) ? '0 : RANK_W'(drem_q - 3'd1));
  end

  // result and write-back values
  always_comb begin
    res_d   = res_q;
    sat_d   = sat_q;
    rank_wd = RANK_INIT;
    acc_wd  = '0;
    rank_we = clearing;
    acc_we  = clearing;
    sum     = '0;
    if (state_q == S_RD) begin
      res_d = (item_q.op == OP_READ) ? rank_rd : '0;
      sat_d = 1'b0;
    end else if (state_q == S_CALC) begin
      if (item_q.op == OP_PUSH) begin
        sum    = {1'b0, acc_q} + {1'b0, quot[RANK_W-1:0]};
        acc_wd = sum[RANK_W] ? RANK_MAX : sum[RANK_W-1:0];
        acc_we = 1'b1;
        res_d  = quot[RANK_W-1:0];
        sat_d  = sum[RANK_W];
      end else begin
        sum     = {1'b0, scaled} + {1'b0, RANK_BASE};
        rank_wd = sum[RANK_W] ? RANK_MAX : sum[RANK_W-1:0];
        rank_we = 1'b1;
        acc_we  = 1'b1;
        res_d   = rank_wd;
        sat_d   = sum[RANK_W];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_cnt_q == '1) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_RD;
      S_RD: begin
        if (item_q.op == OP_APPLY) state_d = S_APL;
        else if (need_div) state_d = S_DIV;
        else state_d = S_FIN;
      end
      S_DIV:   if (div_done) state_d = S_CALC;
      S_APL:   if (dcnt_q == DCNT_W'(NUM_DIG - 1)) state_d = S_CALC;
      S_CALC:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + VTX_W'(1);
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item, operand and output word registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    // acc_q doubles as the digit shift register during apply
    if (state_q == S_RD) begin
      acc_q  <= acc_rd;
      drem_q <= '0;
      dcnt_q <= '0;
    end else if (state_q == S_APL) begin
      acc_q  <= {acc_q[RANK_W-DIG_W-1:0], {DIG_W{1'b0}}};
      dq_q   <= {dq_q[RANK_W-DIG_W-1:0], dig_quo};
      drem_q <= dig_rem[2:0];
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    res_q <= res_d;
    sat_q <= sat_d;
    if (state_q == S_FIN && out_free) begin
      out_q.vertex     <= item_q.dst_vertex;
      out_q.rank_value <= res_q;
      out_q.saturated  <= sat_q;
    end
  end

  assign out_word_o  = out_q;
  assign out_valid_o = out_valid_q;

  // checks
  `PPU_NEVER(a_no_accept_in_clear, clearing && accept)
  `PPU_ASSERT(a_div_done_in_div, div_done |-> state_q == S_DIV)
  `PPU_ASSERT(a_rank_wr_apply, (rank_we && !clearing) |-> item_q.op == OP_APPLY)
endmodule
`default_nettype wire

>>> hw/rtl/ppu_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ppu_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppu_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ppu_pkg::div_req_t      req_i,
  output logic                        done_o,
  output logic [ppu_pkg::DIV_W-1:0]   quot_o
);
  import ppu_pkg::*;

  logic [DEG_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quot_q, quot_d;
  logic [DEG_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEG_W:0]   trial;
  logic             fits;

  // one restoring step
  always_comb begin
    trial  = {rem_q[DEG_W-1:0], quot_q[DIV_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    rem_d  = fits ? trial - {1'b0, dvs_q} : trial;
    quot_d = {quot_q[DIV_W-2:0], fits};
    cnt_d  = cnt_q + CNT_W'(1);
    busy_d = busy_q && (cnt_q != CNT_W'(DIV_W - 1));
    done_d = busy_q && (cnt_q == CNT_W'(DIV_W - 1));
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (busy_q) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.dividend;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

>>> tb/tb_pagerank_push_update_unit.sv
// Self-checking bench for the push PageRank update unit: drives edge, apply
// and read words, predicts ranks and accumulators per vertex, checks results.
// Depends on ppu_pkg and pagerank_push_update_unit.
`timescale 1ns / 1ps
module tb_pagerank_push_update_unit;
  import ppu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  in_word_t  in_word_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  out_word_t out_word_o;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;

  pagerank_push_update_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_word_i(in_word_i), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_word_o(out_word_o), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i)
  );

  always #5 clk_i = ~clk_i;

  // predicted vertex state
  logic [RANK_W-1:0] rank_mem [NUM_VERTICES];
  logic [RANK_W-1:0] acc_mem  [NUM_VERTICES];

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        send_idle_pct = 26;
  int        recv_idle_pct = 50;
  int        errors = 0;
  int        quiet_cycles = 0;
  bit        stim_done = 1'b0;

  // compute one result and update the predicted state
  function automatic out_word_t predict_update(in_word_t w);
    out_word_t         r;
    logic [RANK_W:0]   sum;
    logic [RANK_W-1:0] contrib;
    logic [RANK_W+3:0] scaled;
    r = '0;
    r.vertex = w.dst_vertex;
    case (w.op)
      OP_PUSH: begin
        if (w.src_degree != 0) begin
          contrib = rank_mem[w.src_vertex] / w.src_degree;
          sum = {1'b0, acc_mem[w.dst_vertex]} + contrib;
          if (sum > {1'b0, RANK_MAX}) begin
            acc_mem[w.dst_vertex] = RANK_MAX;
            r.saturated = 1'b1;
          end else begin
            acc_mem[w.dst_vertex] = sum[RANK_W-1:0];
          end
          r.rank_value = contrib;
        end
      end
      OP_APPLY: begin
        scaled = ({4'b0, acc_mem[w.dst_vertex]} * 5) / 6 + RANK_BASE;
        if (scaled > {4'b0, RANK_MAX}) begin
          rank_mem[w.dst_vertex] = RANK_MAX;
          r.saturated = 1'b1;
        end else begin
          rank_mem[w.dst_vertex] = scaled[RANK_W-1:0];
        end
        acc_mem[w.dst_vertex] = '0;
        r.rank_value = rank_mem[w.dst_vertex];
      end
      OP_READ: r.rank_value = rank_mem[w.dst_vertex];
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, int src, int dst, int deg);
    in_word_t w;
    w.op = op;
    w.src_vertex = VTX_W'(src);
    w.dst_vertex = VTX_W'(dst);
    w.src_degree = DEG_W'(deg);
    return w;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // prediction at accept, checking at result, watchdog
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(predict_update(in_word_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          exp_w = expected_results.pop_front();
          if (out_word_o.vertex !== exp_w.vertex) begin
            $error("vertex exp %0d got %0d", exp_w.vertex, out_word_o.vertex);
            errors++;
          end
          if (out_word_o.rank_value !== exp_w.rank_value) begin
            $error("rank_value exp %0d got %0d", exp_w.rank_value,
                   out_word_o.rank_value);
            errors++;
          end
          if (out_word_o.saturated !== exp_w.saturated) begin
            $error("saturated exp %0d got %0d", exp_w.saturated,
                   out_word_o.saturated);
            errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("pagerank_push_update_unit: mismatch");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int v;
    int hot;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      rank_mem[i] = RANK_INIT;
      acc_mem[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every op, field extremes, zero degree, unused op
    pending_words.push_back(make_word(OP_READ, 0, 0, 0));
    pending_words.push_back(make_word(OP_READ, 4095, 4095, 65535));
    pending_words.push_back(make_word(OP_PUSH, 0, 4095, 1));
    pending_words.push_back(make_word(OP_PUSH, 4095, 4095, 65535));
    pending_words.push_back(make_word(OP_PUSH, 1, 4095, 0));
    pending_words.push_back(make_word(OP_PUSH, 2, 4095, 3));
    pending_words.push_back(make_word(OP_APPLY, 0, 4095, 0));
    pending_words.push_back(make_word(OP_READ, 0, 4095, 0));
    pending_words.push_back(make_word(OP_APPLY, 0, 7, 0));
    pending_words.push_back(make_word(2'd3, 4095, 4095, 65535));
    pending_words.push_back(make_word(2'd3, 0, 0, 0));
    // push vertex 5 six times with degree 1 into 6, apply, then push 6 into 10
    for (int i = 0; i < 6; i++)
      pending_words.push_back(make_word(OP_PUSH, 5, 6, 1));
    pending_words.push_back(make_word(OP_APPLY, 0, 6, 1));
    pending_words.push_back(make_word(OP_PUSH, 6, 10, 1));
    pending_words.push_back(make_word(OP_APPLY, 0, 10, 1));
    pending_words.push_back(make_word(OP_READ, 0, 10, 1));

    // random: mostly a small hot vertex set so accumulators and ranks grow
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 170; i++) begin
        hot = $urandom_range(3);
        v = (hot != 0) ? $urandom_range(15) : $urandom_range(4095);
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5:
            pending_words.push_back(make_word(OP_PUSH,
              (hot != 0) ? $urandom_range(15) : $urandom_range(4095), v,
              ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(4)));
          6, 7: pending_words.push_back(make_word(OP_APPLY, $urandom_range(4095), v,
                                                  $urandom_range(65535)));
          8: pending_words.push_back(make_word(OP_READ, $urandom_range(4095), v,
                                               $urandom_range(65535)));
          default: pending_words.push_back(make_word(2'd3, $urandom_range(4095), v,
                                                     $urandom_range(65535)));
        endcase
      end
      while (pending_words.size() > 0 || expected_results.size() > 0)
        @(posedge clk_i);
      if (phase == 0) begin
        send_idle_pct = 50;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("pagerank_push_update_unit: match");
    end else begin
      $display("pagerank_push_update_unit: mismatch");
    end
    $finish;
  end
endmodule
